@@ design/deq_pkg.sv @@
// Shared definitions for the double-ended queue: widths, command codes,
// status codes and the default ring depth.
// Used by deq_ram and double_ended_queue; depends on nothing else.
package deq_pkg;

	// Default number of ring entries.
	localparam int DEQ_DEPTH = 16;

	// Field widths.
	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int STAT_W = 2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

@@ design/deq_ram.sv @@
// Entry store of the queue: one write port and one read port, with the
// read data registered.
// Depends on deq_pkg for the word width.
module deq_ram #(
	parameter int DEPTH  = deq_pkg::DEQ_DEPTH,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [ADDR_W-1:0]                wr_addr,
	input  logic signed [deq_pkg::DATA_W-1:0] wr_data,
	input  logic                             rd_en,
	input  logic [ADDR_W-1:0]                rd_addr,
	output logic signed [deq_pkg::DATA_W-1:0] rd_data
);
	import deq_pkg::*;

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/double_ended_queue.sv @@
// Bounded double-ended queue of signed words in a ring store.
// Push: result strobes the cycle after start; a new command is taken every cycle while busy is low.
// Pop: result via store read and result registers, busy while reading; empty pop answers without busy.
// List: each entry front to back on consecutive cycles, busy while reading; the final one has last set.
// Reset (arst_n low) empties the queue at once; the store itself is not cleared.
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [deq_pkg::CMD_W-1:0]         cmd,
	input  logic signed [deq_pkg::DATA_W-1:0] value,
	output logic                              strobe,
	output logic [deq_pkg::STAT_W-1:0]        status,
	output logic signed [deq_pkg::DATA_W-1:0] data,
	output logic                              last
);
	import deq_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// Controller states.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic                     state_q;
	logic [IDX_W-1:0]         front_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     list_q;
	logic [IDX_W-1:0]         lst_i_q;
	logic [IDX_W-1:0]         rd_pos_q;
	logic                     strobe_q;
	logic [STAT_W-1:0]        status_q;
	logic signed [DATA_W-1:0] data_q;
	logic                     last_q;

	logic                     accept;
	logic                     is_empty;
	logic                     is_full;
	logic                     list_done;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic                     rd_en;
	logic [IDX_W-1:0]         rd_addr;
	logic signed [DATA_W-1:0] rd_data;
	logic [IDX_W-1:0]         front_dec;

	// Reduce a sum of two ring offsets, known to be below twice the depth.
	function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
		return r[IDX_W-1:0];
	endfunction

	assign busy     = (state_q == ST_READ);
	assign accept   = start && !busy;
	assign is_empty = (cnt_q == '0);
	assign is_full  = (cnt_q == DEPTH_C);
	assign front_dec = (front_q == '0) ? LAST_IDX : (front_q - IDX_W'(1));
	// The word now leaving the memory is the final one of the listing, or is a popped word.
	assign list_done = !list_q || ((CNT_W'(lst_i_q) + CNT_W'(1)) == cnt_q);

	// Memory port addressing. Writes happen only on an accepted push and reads
	// only on pops and listings, so the two ports never meet on one entry.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = front_dec;
		rd_en   = 1'b0;
		rd_addr = front_q;
		if (state_q == ST_READ) begin
			rd_en   = !list_done;
			rd_addr = wrap(SUM_W'(rd_pos_q) + SUM_W'(1));
		end else if (accept) begin
			case (cmd)
				CMD_PUSH_FRONT: begin
					wr_en   = !is_full;
					wr_addr = front_dec;
				end
				CMD_PUSH_BACK: begin
					wr_en   = !is_full;
					wr_addr = wrap(SUM_W'(front_q) + SUM_W'(cnt_q));
				end
				CMD_POP_FRONT, CMD_LIST: begin
					rd_en   = !is_empty;
					rd_addr = front_q;
				end
				CMD_POP_BACK: begin
					rd_en   = !is_empty;
					rd_addr = wrap(SUM_W'(front_q) + SUM_W'(cnt_q) - SUM_W'(1));
				end
				default: begin
					wr_en = 1'b0;
					rd_en = 1'b0;
				end
			endcase
		end
	end

	deq_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Queue pointers, controller state and read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			cnt_q   <= '0;
			list_q  <= 1'b0;
			lst_i_q <= '0;
		end else if (state_q == ST_READ) begin
			if (list_done) begin
				state_q <= ST_IDLE;
			end
			lst_i_q <= lst_i_q + IDX_W'(1);
		end else if (accept) begin
			lst_i_q <= '0;
			case (cmd)
				CMD_PUSH_FRONT: begin
					if (!is_full) begin
						front_q <= front_dec;
						cnt_q   <= cnt_q + CNT_W'(1);
					end
				end
				CMD_PUSH_BACK: begin
					if (!is_full) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				CMD_POP_FRONT: begin
					if (!is_empty) begin
						front_q <= wrap(SUM_W'(front_q) + SUM_W'(1));
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= ST_READ;
						list_q  <= 1'b0;
					end
				end
				CMD_POP_BACK: begin
					if (!is_empty) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= ST_READ;
						list_q  <= 1'b0;
					end
				end
				CMD_LIST: begin
					if (!is_empty) begin
						state_q <= ST_READ;
						list_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Ring position of the last issued read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pos_q <= rd_addr;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else if (state_q == ST_READ) begin
			strobe_q <= 1'b1;
		end else if (accept) begin
			strobe_q <= (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK) ||
				(((cmd == CMD_POP_FRONT) || (cmd == CMD_POP_BACK) ||
				(cmd == CMD_LIST)) && is_empty);
		end else begin
			strobe_q <= 1'b0;
		end
	end

	// Result word fields.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			status_q <= STAT_OK;
			data_q   <= rd_data;
			last_q   <= list_done;
		end else begin
			if ((cmd == CMD_POP_FRONT) || (cmd == CMD_POP_BACK) || (cmd == CMD_LIST)) begin
				status_q <= STAT_EMPTY;
			end else if (is_full) begin
				status_q <= STAT_FULL;
			end else begin
				status_q <= STAT_OK;
			end
			data_q <= '0;
			last_q <= 1'b1;
		end
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign data   = data_q;
	assign last   = last_q;

	// The entry count never exceeds the ring depth.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("entry count above depth");

	// The front pointer always names a ring entry.
	a_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= LAST_IDX)
		else $error("front pointer outside ring");

	// A push on a full queue answers at once with status full.
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_full && ((cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK)))
		|=> (strobe && (status == STAT_FULL) && last))
		else $error("full push not reported");

	// Every cycle spent reading yields a word, and the pointers hold meanwhile.
	a_read_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (strobe && $stable(cnt_q) && $stable(front_q)))
		else $error("read cycle without result or with pointer change");

	// A listing, and a pop, ends on a word marked last, and the controller is idle again.
	a_list_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_READ) && list_done) |=> (last && (state_q == ST_IDLE)))
		else $error("read sequence ended without last mark");

endmodule
